### rtl/mbf_pkg.sv
package mbf_pkg;

   // bitmap memory row geometry
   localparam int ROW_BITS = 32;
   localparam int BIT_W    = 5;

   // bank base numbers
   localparam logic [31:0] BASE_LOW  = 32'h0000_0000;
   localparam logic [31:0] BASE_HYP  = 32'h4000_0000;
   localparam logic [31:0] BASE_HIGH = 32'hc000_0000;

   // request action codes
   localparam logic [1:0] ACT_QUERY   = 2'd0;
   localparam logic [1:0] ACT_ENABLE  = 2'd1;
   localparam logic [1:0] ACT_DISABLE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EXISTS = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture request and decode its bit position
      logic clr_en;   // write one zero row of the clearing pass
      logic rd_en;    // read the row that holds the bit
      logic commit;   // write back the row and load the response
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last; // last row of the clearing pass
      logic out_free; // response register can take a new response
   } ctrl_stat_type;

endpackage

### rtl/msr_monitor_bitmap_filter.sv
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_action, req_msr_number
// rsp       out        rsp_valid / rsp_stall     rsp_status, rsp_monitored,
//                                                rsp_intercept_request
//
// each request passes through accept, bitmap row read, and row write-back with
// response load; the single row port of the bitmap memory keeps these steps apart.
// after reset a clearing pass zeroes the bitmap, one 32-bit row a cycle,
// over 3 * BANK_ENTRIES / 32 rows (768 at the default), with req_stall high.
// a held response stalls only the write-back; a new request is taken while
// the previous response still waits in the output register.
module msr_monitor_bitmap_filter
   import mbf_pkg::*;
#(
   parameter int BANK_ENTRIES = 8192
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_msr_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_monitored,
   output logic        rsp_intercept_request
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer
   mbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap and response datapath
   mbf_datapath #(
      .BANK_ENTRIES (BANK_ENTRIES)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_action            (req_action),
      .req_msr_number        (req_msr_number),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_monitored         (rsp_monitored),
      .rsp_intercept_request (rsp_intercept_request),
      .cmd                   (cmd),
      .stat                  (stat)
   );

endmodule

### rtl/mbf_ctrl.sv
module mbf_ctrl
   import mbf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // requests are refused during the clearing pass
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("request taken during clearing pass");

   // an accepted request always goes on to the row read
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_READ)
      else $error("accepted request did not start a row read");

   // a commit only happens when the response register is free
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("commit while response register busy");

endmodule

### rtl/mbf_datapath.sv
module mbf_datapath
   import mbf_pkg::*;
#(
   parameter int BANK_ENTRIES = 8192
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    req_action,
   input  logic [31:0]   req_msr_number,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic          rsp_monitored,
   output logic          rsp_intercept_request,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat
);

   localparam int          POS_W  = $clog2(3 * BANK_ENTRIES);
   localparam int          ROW_W  = POS_W - BIT_W;
   localparam int          ROWS   = (3 * BANK_ENTRIES + ROW_BITS - 1) / ROW_BITS;
   localparam logic [31:0] BANK_N = 32'(BANK_ENTRIES);

   logic [ROW_BITS-1:0] mem [ROWS];

   logic [1:0]          action_ff;
   logic                inside_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [ROW_BITS-1:0] rd_row_ff;
   logic [ROW_W-1:0]    clr_row_ff;
   logic                rsp_valid_ff;
   logic [1:0]          status_ff;
   logic                monitored_ff;
   logic                irq_ff;

   logic [31:0]         off_low;
   logic [31:0]         off_hyp;
   logic [31:0]         off_high;
   logic                in_low;
   logic                in_hyp;
   logic                in_high;
   logic [POS_W-1:0]    pos_in;
   logic [ROW_W-1:0]    row_idx;
   logic                old_bit;
   logic                wr_needed;
   logic                new_bit;
   logic [ROW_BITS-1:0] new_row;
   logic [1:0]          status_in;
   logic                irq_in;

   // bank decode of the incoming number
   always_comb begin
      off_low  = req_msr_number - BASE_LOW;
      off_hyp  = req_msr_number - BASE_HYP;
      off_high = req_msr_number - BASE_HIGH;
      in_low   = off_low < BANK_N;
      in_hyp   = off_hyp < BANK_N;
      in_high  = off_high < BANK_N;
      if (in_low) begin
         pos_in = off_low[POS_W-1:0];
      end else if (in_hyp) begin
         pos_in = off_hyp[POS_W-1:0] + POS_W'(BANK_ENTRIES);
      end else begin
         pos_in = off_high[POS_W-1:0] + POS_W'(2 * BANK_ENTRIES);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         inside_ff <= in_low | in_hyp | in_high;
         pos_ff    <= pos_in;
      end
   end

   assign row_idx = pos_ff[POS_W-1:BIT_W];

   // clearing pass row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff <= '0;
      end else if (cmd.clr_en) begin
         clr_row_ff <= clr_row_ff + 1'b1;
      end
   end

   assign stat.clr_last = clr_row_ff == ROW_W'(ROWS - 1);

   // action evaluation on the fetched row
   always_comb begin
      old_bit   = inside_ff & rd_row_ff[pos_ff[BIT_W-1:0]];
      wr_needed = 1'b0;
      new_bit   = 1'b0;
      irq_in    = 1'b0;
      case (action_ff)
         ACT_ENABLE: begin
            if (old_bit) begin
               status_in = ST_EXISTS;
            end else if (!inside_ff) begin
               status_in = ST_RANGE;
            end else begin
               status_in = ST_OK;
               wr_needed = 1'b1;
               new_bit   = 1'b1;
               irq_in    = 1'b1;
            end
         end
         ACT_DISABLE: begin
            if (!old_bit) begin
               status_in = ST_EXISTS;
            end else begin
               status_in = ST_OK;
               wr_needed = 1'b1;
            end
         end
         default: begin
            status_in = inside_ff ? ST_OK : ST_RANGE;
         end
      endcase
      new_row                     = rd_row_ff;
      new_row[pos_ff[BIT_W-1:0]] = new_bit;
   end

   // bitmap memory, one row port
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         mem[clr_row_ff] <= '0;
      end else if (cmd.commit && wr_needed) begin
         mem[row_idx] <= new_row;
      end
      if (cmd.rd_en) begin
         rd_row_ff <= mem[row_idx];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_in;
         monitored_ff <= old_bit;
         irq_ff       <= irq_in;
      end
   end

   assign stat.out_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_monitored         = monitored_ff;
   assign rsp_intercept_request = irq_ff;

   // a commit always presents a response next cycle
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit lost its response");

   // intercept only on a fresh successful enable
   a_irq_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && irq_ff |-> status_ff == ST_OK && !monitored_ff)
      else $error("intercept raised without a successful enable");

   // clearing pass never shares the memory port with a row read or write-back
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_en && (cmd.commit || cmd.rd_en)))
      else $error("memory port used by clear and request together");

endmodule

### tb/sv/msr_monitor_bitmap_filter_tb.sv
module msr_monitor_bitmap_filter_tb
   import mbf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BANK_ENTRIES = 8192;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LINES = 40;

   // action code the block decodes as a query
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // one response as the block should return it
   typedef struct packed {
      logic [1:0] status;
      logic       monitored;
      logic       intercept_request;
   } msr_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_QUERY;
   logic [31:0] req_msr_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_monitored;
   logic        rsp_intercept_request;

   // predicted bitmap, cleared like the block after reset
   bit              monitor_map [3*BANK_ENTRIES];
   msr_outcome_type pending_outcomes [$];

   int unsigned mismatch_count = 0;
   int unsigned cycles_run     = 0;
   int unsigned req_idle_pct   = 0;
   int unsigned rsp_idle_pct   = 0;

   msr_monitor_bitmap_filter #(
      .BANK_ENTRIES(BANK_ENTRIES)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_msr_number        (req_msr_number),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_monitored         (rsp_monitored),
      .rsp_intercept_request (rsp_intercept_request)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bitmap update and expected response for one request
   function automatic msr_outcome_type predict_outcome(input logic [1:0] action,
                                                       input logic [31:0] msr);
      msr_outcome_type res;
      logic            in_bank;
      logic [31:0]     off;
      int unsigned     pos;
      in_bank = 1'b0;
      pos = 0;
      // find the bank that holds this msr, if any
      for (int b = 0; b < 3; b++) begin
         off = msr - (b == 0 ? BASE_LOW : (b == 1 ? BASE_HYP : BASE_HIGH));
         if (!in_bank && off < BANK_ENTRIES) begin
            in_bank = 1'b1;
            pos = b * BANK_ENTRIES + off;
         end
      end
      res.monitored = in_bank ? monitor_map[pos] : 1'b0;
      res.intercept_request = 1'b0;
      case (action)
         ACT_ENABLE: begin
            if (res.monitored) begin
               res.status = ST_EXISTS;
            end else if (!in_bank) begin
               res.status = ST_RANGE;
            end else begin
               monitor_map[pos] = 1'b1;
               res.status = ST_OK;
               res.intercept_request = 1'b1;
            end
         end
         ACT_DISABLE: begin
            // out of range reads as unmonitored, so already disabled
            if (!res.monitored) begin
               res.status = ST_EXISTS;
            end else begin
               monitor_map[pos] = 1'b0;
               res.status = ST_OK;
            end
         end
         default: begin
            res.status = in_bank ? ST_OK : ST_RANGE;
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES) begin
         $display("mismatch at cycle %0d: %s", cycles_run, what);
      end
      mismatch_count++;
   endtask

   // send one request with a random gap ahead of it
   task automatic send_request(input logic [1:0] action, input logic [31:0] msr);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_msr_number <= msr;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
      pending_outcomes.push_back(predict_outcome(action, msr));
   endtask

   // hold off new requests until every response is back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // response check and random receiver stall
   initial begin
      msr_outcome_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected response: status %0d monitored %0d",
                                         rsp_status, rsp_monitored));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_monitored !== want.monitored) begin
                  report_mismatch($sformatf("monitored %0d, expected %0d",
                                            rsp_monitored, want.monitored));
               end
               if (rsp_intercept_request !== want.intercept_request) begin
                  report_mismatch($sformatf("intercept_request %0d, expected %0d",
                                            rsp_intercept_request,
                                            want.intercept_request));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // run limit
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("msr_monitor_bitmap_filter_tb: FAIL");
      $finish;
   end

   // enable and disable twice on one msr, with queries between
   task automatic test_single_msr();
      send_request(ACT_QUERY, 32'h0000_0000);
      send_request(ACT_ENABLE, 32'h0000_0000);
      send_request(ACT_ENABLE, 32'h0000_0000);
      send_request(ACT_QUERY, 32'h0000_0000);
      send_request(ACT_DISABLE, 32'h0000_0000);
      send_request(ACT_DISABLE, 32'h0000_0000);
   endtask

   // first and last msr of the hyp and high banks, last msr of the low bank
   task automatic test_bank_edges();
      send_request(ACT_ENABLE, BASE_LOW + BANK_ENTRIES - 1);
      send_request(ACT_ENABLE, BASE_HYP);
      send_request(ACT_ENABLE, BASE_HYP + BANK_ENTRIES - 1);
      send_request(ACT_ENABLE, BASE_HIGH);
      send_request(ACT_ENABLE, BASE_HIGH + BANK_ENTRIES - 1);
      send_request(ACT_QUERY, BASE_LOW + BANK_ENTRIES - 1);
   endtask

   // numbers just outside the banks and the top number, all three actions
   task automatic test_out_of_range();
      send_request(ACT_QUERY, BASE_LOW + BANK_ENTRIES);
      send_request(ACT_ENABLE, BASE_HYP - 1);
      send_request(ACT_DISABLE, BASE_HYP + BANK_ENTRIES);
      send_request(ACT_QUERY, BASE_HIGH - 1);
      send_request(ACT_ENABLE, 32'hffff_ffff);
   endtask

   // unused action code acts as a query
   task automatic test_unused_action();
      send_request(ACT_UNUSED, BASE_HIGH + BANK_ENTRIES - 1);
      send_request(ACT_UNUSED, BASE_HIGH + BANK_ENTRIES);
      send_request(ACT_DISABLE, BASE_HIGH + BANK_ENTRIES - 1);
   endtask

   // mostly hot msrs near bank edges, some random noise
   task automatic test_random_mix(input int unsigned count);
      logic [1:0]  action;
      logic [31:0] msr;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(99) < 80) begin
            action = ($urandom_range(19) == 0) ? ACT_UNUSED : 2'($urandom_range(2));
            case ($urandom_range(2))
               0: msr = BASE_LOW;
               1: msr = BASE_HYP;
               default: msr = BASE_HIGH;
            endcase
            case ($urandom_range(4))
               0: msr = msr + $urandom_range(7);
               1: msr = msr + BANK_ENTRIES - 1 - $urandom_range(7);
               2: msr = msr + $urandom_range(BANK_ENTRIES - 1);
               3: msr = msr + BANK_ENTRIES + $urandom_range(3);
               default: msr = msr - 1 - $urandom_range(3);
            endcase
         end else begin
            action = 2'($urandom_range(3));
            msr = $urandom();
         end
         send_request(action, msr);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 31;
      rsp_idle_pct = 53;
      test_single_msr();
      test_bank_edges();
      test_out_of_range();
      test_unused_action();
      wait_for_responses();
      test_random_mix(284);
      wait_for_responses();

      req_idle_pct = 53;
      rsp_idle_pct = 31;
      test_random_mix(283);
      wait_for_responses();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(283);
      wait_for_responses();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("msr_monitor_bitmap_filter_tb: PASS");
      end else begin
         $display("msr_monitor_bitmap_filter_tb: FAIL");
      end
      $finish;
   end

endmodule
